// ----- rtl/rsd_pkg.sv -----
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared types and constants of the running standard deviation core.
// ----------------------------------------------------------------------------
`default_nettype none

package rsd_pkg;

    localparam int COUNT_WIDTH_DEF  = 16;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int STD_W            = 20;  // result width, 12 fraction bits
    localparam int FRAC_SHIFT       = 8;   // radicand pre-shift, must be even

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_UPDATE,
        ST_PREP,
        ST_MUL,
        ST_SUB,
        ST_SQRT,
        ST_DIV,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic square;
        logic update;
        logic prep;
        logic mul;
        logic sub;
        logic sqrt;
        logic div;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;
    } t_sts;

endpackage

`default_nettype wire

// ----- rtl/running_standard_deviation_core.sv -----
// ----------------------------------------------------------------------------
// running_standard_deviation_core
// Running population standard deviation of signed Q8.8 samples.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Group     Contents (low bit first)
//  --------  ---  --------  ------------------------------------------------
//  input     in   s_axis    tdata: sample; tuser: mode (1 = clear)
//  result    out  m_axis    tdata: count, std_dev; tuser: dropped
//
// One item is worked on at a time. An append to a non-empty sequence runs
// through the shift-add multiply of n*Q and S*S, then the bit-serial square
// root and the restoring divide by n, one bit per cycle each. A result for
// an empty sequence (or a clear) skips the multiply, root and divide.
// Synchronous active-low reset clears the sums, the count and all control.
// The output register holds a result while the sink stalls; a new input
// transfer is taken in the meantime, and its result waits until that slot
// frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module running_standard_deviation_core #(
    parameter int COUNT_WIDTH  = rsd_pkg::COUNT_WIDTH_DEF,
    parameter int SAMPLE_WIDTH = rsd_pkg::SAMPLE_WIDTH_DEF,
    localparam int IN_TDATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((COUNT_WIDTH + rsd_pkg::STD_W + 7) / 8) * 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input channel
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // sample
    input  wire logic                   i_s_axis_tuser,   // mode
    // result channel
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,   // count, std_dev
    output logic                        o_m_axis_tuser    // dropped
);

    localparam int CW       = COUNT_WIDTH;
    localparam int SW       = SAMPLE_WIDTH;
    localparam int STD_W    = rsd_pkg::STD_W;
    localparam int MUL_STEPS  = SW + CW;
    localparam int ROOT_STEPS = (2 * (SW + CW) - 2 + rsd_pkg::FRAC_SHIFT) / 2;

    rsd_pkg::t_cmd    w_cmd;
    rsd_pkg::t_sts    w_sts;
    logic [CW-1:0]    w_count;
    logic [STD_W-1:0] w_std_dev;

    rsd_ctrl #(
        .MUL_STEPS  (MUL_STEPS),
        .ROOT_STEPS (ROOT_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    rsd_dpath #(
        .CW (CW),
        .SW (SW)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .i_mode    (i_s_axis_tuser),
        .i_sample  (signed'(i_s_axis_tdata[SW-1:0])),
        .o_count   (w_count),
        .o_std_dev (w_std_dev),
        .o_dropped (o_m_axis_tuser)
    );

    // count in the low bits, std_dev above, zero fill to a byte boundary
    assign o_m_axis_tdata = OUT_TDATA_W'({w_std_dev, w_count});

    // the core never takes a second item right behind the first
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken while an item is being worked on");

    // a refused append only happens with a full counter
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata[CW-1:0] == {CW{1'b1}}))
        else $error("dropped flag with a counter that is not full");

    // empty sequence reports zero deviation
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[CW-1:0] == '0))
            |-> (o_m_axis_tdata[CW+STD_W-1:CW] == '0))
        else $error("nonzero deviation for an empty sequence");

endmodule

`default_nettype wire

// ----- rtl/rsd_ctrl.sv -----
// ----------------------------------------------------------------------------
// rsd_ctrl
// Sequencer: steps the datapath through update, multiply, root and divide.
// ----------------------------------------------------------------------------
`default_nettype none

module rsd_ctrl #(
    parameter int MUL_STEPS  = 32,
    parameter int ROOT_STEPS = 35
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire rsd_pkg::t_sts i_sts,
    output rsd_pkg::t_cmd      o_cmd
);

    localparam int STEP_W = (ROOT_STEPS > 1) ? $clog2(ROOT_STEPS) : 1;

    rsd_pkg::t_state r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rsd_pkg::ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            rsd_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = rsd_pkg::ST_SQUARE;
                end
            end
            rsd_pkg::ST_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = rsd_pkg::ST_UPDATE;
            end
            rsd_pkg::ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = rsd_pkg::ST_PREP;
            end
            rsd_pkg::ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_step     = STEP_W'(MUL_STEPS - 1);
                n_state    = i_sts.empty ? rsd_pkg::ST_OUT : rsd_pkg::ST_MUL;
            end
            rsd_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_step    = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = rsd_pkg::ST_SUB;
                end
            end
            rsd_pkg::ST_SUB: begin
                o_cmd.sub = 1'b1;
                n_step    = STEP_W'(ROOT_STEPS - 1);
                n_state   = rsd_pkg::ST_SQRT;
            end
            rsd_pkg::ST_SQRT: begin
                o_cmd.sqrt = 1'b1;
                n_step     = r_step - 1'b1;
                if (r_step == '0) begin
                    n_step  = STEP_W'(ROOT_STEPS - 1);
                    n_state = rsd_pkg::ST_DIV;
                end
            end
            rsd_pkg::ST_DIV: begin
                o_cmd.div = 1'b1;
                n_step    = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = rsd_pkg::ST_OUT;
                end
            end
            rsd_pkg::ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = rsd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rsd_pkg::ST_IDLE;
            end
        endcase
    end

    // output register flag: set on load, cleared when the result is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- rtl/rsd_dpath.sv -----
// ----------------------------------------------------------------------------
// rsd_dpath
// Running sums, shift-add multipliers, bit-serial square root and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module rsd_dpath #(
    parameter int CW = rsd_pkg::COUNT_WIDTH_DEF,
    parameter int SW = rsd_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire rsd_pkg::t_cmd        i_cmd,
    output rsd_pkg::t_sts             o_sts,
    input  wire logic                 i_mode,
    input  wire logic signed [SW-1:0] i_sample,
    output logic [CW-1:0]             o_count,
    output logic [rsd_pkg::STD_W-1:0] o_std_dev,
    output logic                      o_dropped
);

    localparam int STD_W  = rsd_pkg::STD_W;
    localparam int SUM_W  = SW + CW + 1;
    localparam int MAG_W  = SW + CW;
    localparam int SQ_W   = 2 * SW;
    localparam int QSUM_W = 2 * SW + CW;
    localparam int D_W    = 2 * (SW + CW) - 2;
    localparam int RAD_W  = D_W + rsd_pkg::FRAC_SHIFT;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    // running state
    logic [CW-1:0]            r_count;
    logic signed [SUM_W-1:0]  r_sum;
    logic [QSUM_W-1:0]        r_qsum;

    // item and work registers
    logic                     r_mode;
    logic signed [SW-1:0]     r_sample;
    logic [SQ_W-1:0]          r_sq;
    logic                     r_dropped;
    logic [CW-1:0]            r_mul_n;
    logic [MAG_W-1:0]         r_mul_s;
    logic [D_W-1:0]           r_mcand_q, r_mcand_s, r_acc_a, r_acc_b;
    logic [RAD_W-1:0]         r_rad;
    logic [ROOT_W-1:0]        r_root;   // root, then dividend/quotient
    logic [REM_W-1:0]         r_rem;
    logic [CW-1:0]            r_drem;
    logic [CW-1:0]            r_out_count;
    logic [STD_W-1:0]         r_out_std;
    logic                     r_out_dropped;

    logic signed [SQ_W-1:0]   w_sq;
    logic [SUM_W-1:0]         w_neg;
    logic [MAG_W-1:0]         w_mag;
    logic [D_W:0]             w_diff;
    logic [REM_W-1:0]         w_rem_sh, w_trial;
    logic [REM_W:0]           w_rtry;
    logic [CW:0]              w_dsh;
    logic [CW+1:0]            w_dtry;
    logic [ROOT_W+STD_W-1:0]  w_qx;

    assign w_sq     = r_sample * r_sample;
    assign w_neg    = -r_sum;
    assign w_mag    = r_sum[SUM_W-1] ? w_neg[MAG_W-1:0] : r_sum[MAG_W-1:0];
    assign w_diff   = {1'b0, r_acc_a} - {1'b0, r_acc_b};
    assign w_rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1:RAD_W-2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_rtry   = {1'b0, w_rem_sh} - {1'b0, w_trial};
    assign w_dsh    = {r_drem, r_root[ROOT_W-1]};
    assign w_dtry   = {1'b0, w_dsh} - {2'b00, r_count};
    assign w_qx     = {{STD_W{1'b0}}, r_root};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_qsum  <= '0;
        end else if (i_cmd.update) begin
            if (r_mode) begin
                r_count <= '0;
                r_sum   <= '0;
                r_qsum  <= '0;
            end else if (r_count != '1) begin
                r_count <= r_count + 1'b1;
                r_sum   <= r_sum + SUM_W'(r_sample);
                r_qsum  <= r_qsum + QSUM_W'(r_sq);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode   <= i_mode;
            r_sample <= i_sample;
        end
        if (i_cmd.square) begin
            r_sq <= unsigned'(w_sq);
        end
        if (i_cmd.update) begin
            r_dropped <= !r_mode && (r_count == '1);
        end
        if (i_cmd.prep) begin
            r_mul_n   <= r_count;
            r_mul_s   <= w_mag;
            r_mcand_q <= D_W'(r_qsum);
            r_mcand_s <= D_W'(w_mag);
            r_acc_a   <= '0;
            r_acc_b   <= '0;
        end
        if (i_cmd.mul) begin
            if (r_mul_n[0]) begin
                r_acc_a <= r_acc_a + r_mcand_q;
            end
            if (r_mul_s[0]) begin
                r_acc_b <= r_acc_b + r_mcand_s;
            end
            r_mcand_q <= r_mcand_q << 1;
            r_mcand_s <= r_mcand_s << 1;
            r_mul_n   <= r_mul_n >> 1;
            r_mul_s   <= r_mul_s >> 1;
        end
        if (i_cmd.sub) begin
            // n*Q - S*S, clamped at zero, scaled for the fraction bits
            r_rad  <= {(w_diff[D_W] ? {D_W{1'b0}} : w_diff[D_W-1:0]),
                       {rsd_pkg::FRAC_SHIFT{1'b0}}};
            r_root <= '0;
            r_rem  <= '0;
            r_drem <= '0;
        end
        if (i_cmd.sqrt) begin
            r_rad <= r_rad << 2;
            if (!w_rtry[REM_W]) begin
                r_rem  <= w_rtry[REM_W-1:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.div) begin
            // restoring division by the count, quotient shifts into r_root
            if (!w_dtry[CW+1]) begin
                r_drem <= w_dtry[CW-1:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_drem <= w_dsh[CW-1:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.load_out) begin
            r_out_count   <= r_count;
            r_out_std     <= (r_count == '0) ? '0 : w_qx[STD_W-1:0];
            r_out_dropped <= r_dropped;
        end
    end

    assign o_sts.empty = (r_count == '0);
    assign o_count     = r_out_count;
    assign o_std_dev   = r_out_std;
    assign o_dropped   = r_out_dropped;

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for running_standard_deviation_core. Drives append
// and clear items on the input stream, predicts count, deviation and drop
// flag per item, and compares every result transfer in order. The core is
// built with its default widths.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CNT_W   = rsd_pkg::COUNT_WIDTH_DEF;
    localparam int SMP_W   = rsd_pkg::SAMPLE_WIDTH_DEF;
    localparam int STD_W   = rsd_pkg::STD_W;
    localparam int IN_W    = ((SMP_W + 7) / 8) * 8;
    localparam int OUT_W   = ((CNT_W + STD_W + 7) / 8) * 8;

    localparam int N_DIRECT_FILL = 100;  // appends with no clear at all
    localparam int N_RANDOM      = 350;  // mixed appends and clears
    localparam int HOLD_AT       = 150;  // result index where the sink backs off
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 200;  // well beyond the per-item latency

    // ------------------------------------------------------------------------
    // Expected-result store and predictor
    // ------------------------------------------------------------------------
    typedef struct {
        logic [CNT_W-1:0] count;
        logic [STD_W-1:0] std_dev;
        logic             dropped;
    } t_stat;

    class rsd_scoreboard;
        logic [CNT_W-1:0]   held_n;
        logic signed [32:0] held_sum;
        logic [45:0]        held_sq;
        t_stat              pending_stats[$];
        int                 errors;

        function new();
            held_n   = '0;
            held_sum = '0;
            held_sq  = '0;
            errors   = 0;
        endfunction

        // floor(floor(sqrt((n*Q - S*S) << 8)) / n), 0 for an empty set
        function logic [STD_W-1:0] std_of_held();
            logic [63:0] nq;
            logic [63:0] mag;
            logic [63:0] ss;
            logic [63:0] d;
            logic [71:0] rad;
            logic [79:0] rem;
            logic [79:0] trial;
            logic [79:0] root;
            logic [79:0] quot;
            if (held_n == '0) return '0;
            nq   = 64'(held_n) * 64'(held_sq);
            mag  = (held_sum < 0) ? 64'(-held_sum) : 64'(held_sum);
            ss   = mag * mag;
            d    = (nq > ss) ? nq - ss : 64'd0;
            rad  = 72'(d) << rsd_pkg::FRAC_SHIFT;
            rem  = '0;
            root = '0;
            // digit-by-digit root, two radicand bits per step
            for (int p = 70; p >= 0; p -= 2) begin
                rem   = (rem << 2) | 80'(rad[p+:2]);
                trial = (root << 2) | 80'd1;
                if (rem >= trial) begin
                    rem  = rem - trial;
                    root = (root << 1) | 80'd1;
                end else begin
                    root = root << 1;
                end
            end
            quot = root / 80'(held_n);
            return quot[STD_W-1:0];
        endfunction

        function void note_input(logic clear, logic [SMP_W-1:0] raw);
            t_stat             s;
            logic signed [SMP_W-1:0] x;
            x         = raw;
            s.dropped = 1'b0;
            if (clear) begin
                held_n   = '0;
                held_sum = '0;
                held_sq  = '0;
            end else if (held_n == '1) begin
                s.dropped = 1'b1;   // counter full: state left alone
            end else begin
                held_n   = held_n + 1'b1;
                held_sum = held_sum + x;
                held_sq  = held_sq + 46'(64'(x) * 64'(x));
            end
            s.count   = held_n;
            s.std_dev = std_of_held();
            pending_stats.push_back(s);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_result(logic [OUT_W-1:0] data, logic user);
            t_stat s;
            if (pending_stats.size() == 0) begin
                report($sformatf("unexpected result data=%h user=%b", data, user));
                return;
            end
            s = pending_stats.pop_front();
            if (data[CNT_W-1:0] !== s.count)
                report($sformatf("count got %0d want %0d", data[CNT_W-1:0], s.count));
            if (data[CNT_W+:STD_W] !== s.std_dev)
                report($sformatf("std_dev got %0d want %0d (count %0d)",
                                 data[CNT_W+:STD_W], s.std_dev, s.count));
            if (data[OUT_W-1:CNT_W+STD_W] !== '0)
                report($sformatf("tdata padding not zero: %h", data));
            if (user !== s.dropped)
                report($sformatf("dropped got %b want %b (count %0d)",
                                 user, s.dropped, s.count));
        endtask

        function int pending();
            return pending_stats.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_valid = 1'b0;
    logic [IN_W-1:0]  s_data = '0;     // sample
    logic             s_user = 1'b0;   // mode: 1 = clear
    logic             m_ready = 1'b0;
    logic             s_ready;
    logic             m_valid;
    logic [OUT_W-1:0] m_data;          // count, std_dev, zero pad
    logic             m_user;          // dropped

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    running_standard_deviation_core #(
        .COUNT_WIDTH  (CNT_W),
        .SAMPLE_WIDTH (SMP_W)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    rsd_scoreboard sb = new();

    int sent_n = 0;   // input transfers so far
    int got_n  = 0;   // result transfers so far

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Offers one item and returns at the edge where it transfers. Outputs are
    // read right after the edge, i.e. before the core's own updates land.
    task automatic send_item(logic clear, logic [SMP_W-1:0] smp);
        bit quiet;
        quiet = (sent_n >= 200 && sent_n < 300);
        if (!quiet && $urandom_range(0, 99) < 7) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= IN_W'(smp);
        s_user  <= clear;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        sb.note_input(clear, smp);
        sent_n++;
    endtask

    task automatic append(logic [SMP_W-1:0] smp);
        send_item(1'b0, smp);
    endtask

    task automatic clear_seq(logic [SMP_W-1:0] junk);
        send_item(1'b1, junk);
    endtask

    // Mix of full-range values, extremes, near-zero and tight clusters.
    function automatic logic [SMP_W-1:0] any_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 15)) - 16'd8;
            3:       return 16'h7F00 + 16'($urandom_range(0, 255));
            default: return 16'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stalls, one long hold-off, one stall-free stretch
    // ------------------------------------------------------------------------
    initial begin : sink
        int  hold_left;
        bit  held;
        bit  quiet;
        hold_left = 0;
        held      = 1'b0;
        wait (rst_n);
        forever begin
            quiet = (got_n >= 250 && got_n < 350);
            if (got_n == HOLD_AT && !held) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= quiet || ($urandom_range(0, 99) >= 7);
            end
            @(posedge clk);
            if (m_valid && m_ready) begin
                sb.check_result(m_data, m_user);
                got_n++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin : stim
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty clear, extremes, single sample, equal samples
        clear_seq(16'h0000);     // clear of an empty sequence
        append(16'h0000);        // single sample
        append(16'h7FFF);
        append(16'h8000);        // widest possible spread
        append(16'hFFFF);
        append(16'h0001);
        clear_seq(16'hFFFF);     // sample bits ignored on clear
        append(16'h8000);        // single most-negative sample
        append(16'h8000);        // two equal samples
        append(16'h8000);
        append(16'h7FFF);
        clear_seq(16'h5A5A);
        clear_seq(16'hA5A5);
        append(16'h7FFF);
        append(16'h7FFF);
        append(16'h8000);
        append(16'h8000);
        append(16'h0100);        // 1.0
        append(16'hFF00);        // -1.0
        clear_seq(16'h8000);

        // long append run: sums grow large with extreme samples
        repeat (N_DIRECT_FILL) append(any_sample());

        // mostly appends, occasional clear
        repeat (N_RANDOM) begin
            if ($urandom_range(0, 99) < 3)
                clear_seq(16'($urandom()));
            else
                append(any_sample());
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: far above the slowest legal run (~500 items, plus stalls and
    // the long hold-off).
    initial begin : watchdog
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
